[rtl/smtd_pkg.sv]
package smtd_pkg;

  localparam int MAX_WORDS_DEF = 65536;
  localparam int JOB_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  // configuration register indexes
  localparam logic [1:0] CFG_BANK_KEY      = 2'd0;
  localparam logic [1:0] CFG_MESSAGE_COUNT = 2'd1;
  localparam logic [1:0] CFG_BANK_SIZE     = 2'd2;

  localparam int          KEY_MUL_FULL = 765;
  localparam int          KS_MUL_FULL  = 596947;
  localparam logic [15:0] KEY_MUL      = 16'(KEY_MUL_FULL);
  localparam logic [15:0] KS_MUL       = 16'(KS_MUL_FULL % 65536);
  localparam logic [15:0] KS_STEP      = 16'd18749;

  localparam logic [15:0] CODE_END     = 16'hffff;
  localparam logic [15:0] CODE_CTRL    = 16'hfffe;
  localparam logic [15:0] CODE_NL      = 16'he000;
  localparam logic [15:0] CODE_NL_ALT  = 16'h25bc;
  localparam logic [15:0] CODE_PAGE    = 16'h25bd;
  localparam logic [15:0] FN_PLAYER    = 16'h0103;
  localparam logic [15:0] FN_SLOT      = 16'h0100;

  typedef enum logic [2:0] {
    KIND_HDR    = 3'd0,
    KIND_CHAR   = 3'd1,
    KIND_NL     = 3'd2,
    KIND_PAGE   = 3'd3,
    KIND_PLAYER = 3'd4,
    KIND_SLOT   = 3'd5,
    KIND_END    = 3'd6
  } kind_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] message_index;
    logic [31:0] raw_offset;
    logic [31:0] raw_length;
    logic [15:0] text_word;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] header_offset;
    logic [16:0] header_length;
    logic        header_ok;
    logic [6:0]  ascii_char;
    logic [15:0] string_slot;
    logic        last;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  ch;
    logic [15:0] slot;
  } tok_t;

  // one queued job: the header fields or up to four tokens of one text word
  typedef struct packed {
    logic        is_hdr;
    logic [31:0] hdr_offset;
    logic [16:0] hdr_length;
    logic        hdr_ok;
    logic [2:0]  n;
    tok_t [3:0]  tok;
  } job_t;

  typedef struct packed {
    logic [1:0] n;
    logic [6:0] c0;
    logic [6:0] c1;
    logic [6:0] c2;
  } glyph_t;

  function automatic glyph_t glyph_map(input logic [15:0] c);
    glyph_t     g;
    logic [15:0] d;
    g = '0;
    d = '0;
    if (c >= 16'h0121 && c <= 16'h012a) begin
      d = c - 16'h0121;
      g.n = 2'd1;
      g.c0 = 7'h30 + d[6:0];
    end else if (c >= 16'h012b && c <= 16'h0144) begin
      d = c - 16'h012b;
      g.n = 2'd1;
      g.c0 = 7'h41 + d[6:0];
    end else if (c >= 16'h0145 && c <= 16'h015e) begin
      d = c - 16'h0145;
      g.n = 2'd1;
      g.c0 = 7'h61 + d[6:0];
    end else begin
      g.n = 2'd1;
      case (c)
        16'h01de, 16'h01e2: g.c0 = 7'h20;
        16'h01ab: g.c0 = 7'h21;
        16'h01ac: g.c0 = 7'h3f;
        16'h01ad: g.c0 = 7'h2c;
        16'h01ae, 16'h01b0: g.c0 = 7'h2e;
        16'h01af: begin
          g.n = 2'd3;
          g.c0 = 7'h2e;
          g.c1 = 7'h2e;
          g.c2 = 7'h2e;
        end
        16'h01b1: g.c0 = 7'h2f;
        16'h01b2, 16'h01b3: g.c0 = 7'h27;
        16'h01b4, 16'h01b5, 16'h01b6: g.c0 = 7'h22;
        16'h01b9: g.c0 = 7'h28;
        16'h01ba: g.c0 = 7'h29;
        16'h01bb: g.c0 = 7'h4d;
        16'h01bc: g.c0 = 7'h46;
        16'h01bd: g.c0 = 7'h2b;
        16'h01be: g.c0 = 7'h2d;
        16'h01bf: g.c0 = 7'h2a;
        16'h01c0: g.c0 = 7'h23;
        16'h01c1: g.c0 = 7'h3d;
        16'h01c2: g.c0 = 7'h26;
        16'h01c3: g.c0 = 7'h7e;
        16'h01c4: g.c0 = 7'h3a;
        16'h01c5: g.c0 = 7'h3b;
        16'h01d0: g.c0 = 7'h40;
        16'h01d2: g.c0 = 7'h25;
        16'h01e8: begin
          g.n = 2'd3;
          g.c0 = 7'h64;
          g.c1 = 7'h65;
          g.c2 = 7'h67;
        end
        16'h01e9: g.c0 = 7'h5f;
        16'h0188: g.c0 = 7'h65;
        16'h0167: g.c0 = 7'h45;
        16'h0170: g.c0 = 7'h4e;
        16'h0190: g.c0 = 7'h6e;
        default: g.n = 2'd0;
      endcase
    end
    return g;
  endfunction

endpackage

[rtl/scrambled_message_text_decoder.sv]
// Scrambled message text decoder. Load bank_key, message_count and bank_size, push a header
// item for a message, then push its text words. A header item gives one header result after
// the front end's seed multiply and then its unscramble and bounds check; in_full is high
// during the second of them. Text words are taken one per cycle while no header is pending
// and the job queue has room; each gives zero to four results (a glyph of up to three
// characters plus an end mark), and the back end hands out one result per cycle while a job
// is queued and the result queue has room. A word's first result is registered in the job
// queue and then in the result queue before it reaches the result ports; a header result is
// registered in the front end's seed stage first. The last result of each item carries last.
// Text words that arrive with no message open are dropped without a result.
module scrambled_message_text_decoder #(
  parameter int MAX_WORDS = smtd_pkg::MAX_WORDS_DEF,
  parameter int JOB_DEPTH = smtd_pkg::JOB_DEPTH_DEF,
  parameter int OUT_DEPTH = smtd_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [23:0]         cfg_wdata,
  input  logic                in_push,
  output logic                in_full,
  input  smtd_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output smtd_pkg::out_item_t out_data
);

  localparam int JW = $bits(smtd_pkg::job_t);
  localparam int OW = $bits(smtd_pkg::out_item_t);

  smtd_pkg::job_t      job_in, job_out;
  logic                job_push, job_pop, job_full, job_empty;
  smtd_pkg::out_item_t res;
  logic                res_push, res_full;

  smtd_front #(
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (job_in)
  );

  smtd_fifo #(
    .WIDTH (JW),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .pop   (job_pop),
    .rdata (job_out),
    .full  (job_full),
    .empty (job_empty)
  );

  smtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  smtd_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .pop   (out_pop),
    .rdata (out_data),
    .full  (res_full),
    .empty (out_empty)
  );

endmodule

[rtl/smtd_fifo.sv]
module smtd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/smtd_front.sv]
module smtd_front #(
  parameter int MAX_WORDS = smtd_pkg::MAX_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  smtd_pkg::in_item_t in_data,
  input  logic               job_full,
  output logic               job_push,
  output smtd_pkg::job_t     job
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TEXT,
    PH_FUNC,
    PH_ARGC,
    PH_ARGS
  } phase_t;

  localparam logic [31:0] MAX_LEN = 32'(MAX_WORDS);

  // configuration (key is kept premultiplied by the seed factor)
  logic [15:0] key_mul_r;
  logic [15:0] msg_count_r;
  logic [23:0] bank_size_r;

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [15:0] ks_r, ks_nxt;
  logic [16:0] words_left_r, words_left_nxt;
  logic [15:0] held_fn_r, held_fn_nxt;
  logic [15:0] args_left_r, args_left_nxt;
  logic [15:0] first_arg_r, first_arg_nxt;
  logic        have_arg_r, have_arg_nxt;

  // header second stage
  logic        hdr_pend_r, hdr_pend_nxt;
  logic [15:0] seed_r, seed_nxt;
  logic [15:0] ks_seed_r, ks_seed_nxt;
  logic [15:0] hdr_idx_r, hdr_idx_nxt;
  logic [31:0] roff_r, roff_nxt;
  logic [31:0] rlen_r, rlen_nxt;

  logic        accept;
  logic [15:0] idx_p1;
  logic [31:0] seed32, off, len;
  logic        bank_ok, idx_ok, len_ok, span_ok, hdr_ok;
  logic [23:0] table_end;
  logic [32:0] span;
  logic [15:0] c, args_dec;
  logic        end_msg, emit_ctl, emit_end, emit_nl, emit_page, emit_glyph;
  smtd_pkg::glyph_t g;
  smtd_pkg::tok_t   ctl_tok;
  logic [2:0]  n;

  assign in_full = hdr_pend_r | job_full;
  assign accept  = in_push & ~in_full;

  always_comb begin
    phase_nxt      = phase_r;
    ks_nxt         = ks_r;
    words_left_nxt = words_left_r;
    held_fn_nxt    = held_fn_r;
    args_left_nxt  = args_left_r;
    first_arg_nxt  = first_arg_r;
    have_arg_nxt   = have_arg_r;
    hdr_pend_nxt   = hdr_pend_r;
    seed_nxt       = seed_r;
    ks_seed_nxt    = ks_seed_r;
    hdr_idx_nxt    = hdr_idx_r;
    roff_nxt       = roff_r;
    rlen_nxt       = rlen_r;
    job_push       = 1'b0;
    job            = '0;
    n              = '0;

    idx_p1    = in_data.message_index + 16'd1;
    seed32    = {seed_r, seed_r};
    off       = roff_r ^ seed32;
    len       = rlen_r ^ seed32;
    table_end = 24'd4 + {5'd0, msg_count_r, 3'b000};
    bank_ok   = (msg_count_r != '0) && (table_end <= bank_size_r);
    idx_ok    = hdr_idx_r < msg_count_r;
    len_ok    = len <= MAX_LEN;
    span      = {1'b0, off} + {15'd0, len[16:0], 1'b0};
    span_ok   = span <= {9'd0, bank_size_r};
    hdr_ok    = bank_ok & idx_ok & len_ok & span_ok;

    c          = in_data.text_word ^ ks_r;
    args_dec   = args_left_r - 16'd1;
    g          = smtd_pkg::glyph_map(c);
    end_msg    = 1'b0;
    emit_ctl   = 1'b0;
    emit_end   = 1'b0;
    emit_nl    = 1'b0;
    emit_page  = 1'b0;
    emit_glyph = 1'b0;
    ctl_tok    = '0;

    if (hdr_pend_r) begin
      if (!job_full) begin
        hdr_pend_nxt       = 1'b0;
        job_push           = 1'b1;
        job.is_hdr         = 1'b1;
        job.hdr_offset     = off;
        job.hdr_length     = hdr_ok ? len[16:0] : '0;
        job.hdr_ok         = hdr_ok;
        job.n              = 3'd1;
        job.tok[0].kind    = smtd_pkg::KIND_HDR;
        phase_nxt          = PH_IDLE;
        words_left_nxt     = '0;
        if (hdr_ok) begin
          ks_nxt         = ks_seed_r;
          words_left_nxt = len[16:0];
          held_fn_nxt    = '0;
          args_left_nxt  = '0;
          first_arg_nxt  = '0;
          have_arg_nxt   = 1'b0;
          if (len[16:0] != '0) begin
            phase_nxt = PH_TEXT;
          end
        end
      end
    end else if (accept && !in_data.operation) begin
      hdr_pend_nxt = 1'b1;
      seed_nxt     = 16'(key_mul_r * idx_p1);
      ks_seed_nxt  = 16'(idx_p1 * smtd_pkg::KS_MUL);
      hdr_idx_nxt  = in_data.message_index;
      roff_nxt     = in_data.raw_offset;
      rlen_nxt     = in_data.raw_length;
    end else if (accept && phase_r != PH_IDLE) begin
      ks_nxt         = ks_r + smtd_pkg::KS_STEP;
      words_left_nxt = words_left_r - 17'd1;
      case (phase_r)
        PH_TEXT: begin
          if (c == smtd_pkg::CODE_END) begin
            emit_end       = 1'b1;
            phase_nxt      = PH_IDLE;
            words_left_nxt = '0;
          end else if (c == smtd_pkg::CODE_CTRL && words_left_r >= 17'd3) begin
            phase_nxt = PH_FUNC;
          end else if (c == smtd_pkg::CODE_NL || c == smtd_pkg::CODE_NL_ALT) begin
            emit_nl = 1'b1;
          end else if (c == smtd_pkg::CODE_PAGE) begin
            emit_page = 1'b1;
          end else begin
            emit_glyph = 1'b1;
          end
        end
        PH_FUNC: begin
          held_fn_nxt = c;
          phase_nxt   = PH_ARGC;
        end
        PH_ARGC: begin
          args_left_nxt = c;
          first_arg_nxt = '0;
          have_arg_nxt  = 1'b0;
          if (c == '0) begin
            emit_ctl  = 1'b1;
            phase_nxt = PH_TEXT;
          end else begin
            phase_nxt = PH_ARGS;
          end
        end
        PH_ARGS: begin
          if (!have_arg_r) begin
            first_arg_nxt = c;
            have_arg_nxt  = 1'b1;
          end
          args_left_nxt = args_dec;
          if (args_dec == '0) begin
            emit_ctl  = 1'b1;
            phase_nxt = PH_TEXT;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase

      // message ran out: flush a cut-short control, then close
      if (!emit_end && words_left_nxt == '0) begin
        end_msg = 1'b1;
        if (phase_nxt == PH_ARGS) begin
          emit_ctl = 1'b1;
        end
        emit_end  = 1'b1;
        phase_nxt = PH_IDLE;
      end

      if (held_fn_nxt == smtd_pkg::FN_PLAYER) begin
        ctl_tok.kind = smtd_pkg::KIND_PLAYER;
      end else begin
        ctl_tok.kind = smtd_pkg::KIND_SLOT;
        ctl_tok.slot = have_arg_nxt ? first_arg_nxt : '0;
      end

      if (emit_nl) begin
        job.tok[n[1:0]].kind = smtd_pkg::KIND_NL;
        n = n + 3'd1;
      end
      if (emit_page) begin
        job.tok[n[1:0]].kind = smtd_pkg::KIND_PAGE;
        n = n + 3'd1;
      end
      if (emit_glyph && g.n != '0) begin
        job.tok[n[1:0]].kind = smtd_pkg::KIND_CHAR;
        job.tok[n[1:0]].ch   = g.c0;
        n = n + 3'd1;
        if (g.n == 2'd3) begin
          job.tok[n[1:0]].kind = smtd_pkg::KIND_CHAR;
          job.tok[n[1:0]].ch   = g.c1;
          n = n + 3'd1;
          job.tok[n[1:0]].kind = smtd_pkg::KIND_CHAR;
          job.tok[n[1:0]].ch   = g.c2;
          n = n + 3'd1;
        end
      end
      if (emit_ctl && (held_fn_nxt == smtd_pkg::FN_PLAYER ||
                       held_fn_nxt == smtd_pkg::FN_SLOT)) begin
        job.tok[n[1:0]] = ctl_tok;
        n = n + 3'd1;
      end
      if (emit_end) begin
        job.tok[n[1:0]].kind = smtd_pkg::KIND_END;
        n = n + 3'd1;
      end
      job.n    = n;
      job_push = (n != '0) && (end_msg || !end_msg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mul_r    <= '0;
      msg_count_r  <= '0;
      bank_size_r  <= '0;
      phase_r      <= PH_IDLE;
      ks_r         <= '0;
      words_left_r <= '0;
      held_fn_r    <= '0;
      args_left_r  <= '0;
      first_arg_r  <= '0;
      have_arg_r   <= 1'b0;
      hdr_pend_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          smtd_pkg::CFG_BANK_KEY:
            key_mul_r <= 16'(cfg_wdata[15:0] * smtd_pkg::KEY_MUL);
          smtd_pkg::CFG_MESSAGE_COUNT: msg_count_r <= cfg_wdata[15:0];
          smtd_pkg::CFG_BANK_SIZE:     bank_size_r <= cfg_wdata;
          default: ;
        endcase
      end
      phase_r      <= phase_nxt;
      ks_r         <= ks_nxt;
      words_left_r <= words_left_nxt;
      held_fn_r    <= held_fn_nxt;
      args_left_r  <= args_left_nxt;
      first_arg_r  <= first_arg_nxt;
      have_arg_r   <= have_arg_nxt;
      hdr_pend_r   <= hdr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seed_r    <= seed_nxt;
    ks_seed_r <= ks_seed_nxt;
    hdr_idx_r <= hdr_idx_nxt;
    roff_r    <= roff_nxt;
    rlen_r    <= rlen_nxt;
  end

endmodule

[rtl/smtd_back.sv]
module smtd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  smtd_pkg::job_t      job,
  input  logic                job_empty,
  output logic                job_pop,
  input  logic                res_full,
  output logic                res_push,
  output smtd_pkg::out_item_t res
);

  logic [1:0]     idx_r, idx_nxt;
  smtd_pkg::tok_t tok;
  logic           fire, is_last;
  logic [2:0]     last_idx;

  assign tok      = job.tok[idx_r];
  assign last_idx = job.n - 3'd1;
  assign is_last  = ({1'b0, idx_r} == last_idx);
  assign fire     = ~job_empty & ~res_full;
  assign res_push = fire;
  assign job_pop  = fire & is_last;

  always_comb begin
    res               = '0;
    res.kind          = tok.kind;
    res.ascii_char    = tok.ch;
    res.string_slot   = tok.slot;
    res.last          = is_last;
    if (job.is_hdr) begin
      res.header_offset = job.hdr_offset;
      res.header_length = job.hdr_length;
      res.header_ok     = job.hdr_ok;
    end
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = is_last ? '0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

[verif/tb.sv]
module tb;
  import smtd_pkg::*;

  localparam logic        OP_HEADER    = 1'b0;
  localparam logic        OP_TEXT      = 1'b1;
  localparam logic [31:0] SEED_MUL     = 32'd765;
  localparam logic [31:0] START_MUL    = 32'd596947;
  localparam logic [15:0] KEY_ADVANCE  = 16'd18749;
  localparam logic [31:0] LEN_LIMIT    = 32'd65536;
  localparam int          SETTLE       = 8;
  localparam int          QUIET_LIMIT  = 2000;

  localparam logic [15:0] GLYPH_DIGIT0   = 16'h0121;
  localparam logic [15:0] GLYPH_UPPER_A  = 16'h012b;
  localparam logic [15:0] GLYPH_LOWER_Z  = 16'h015e;
  localparam logic [15:0] GLYPH_ELLIPSIS = 16'h01af;
  localparam logic [15:0] GLYPH_DEGREE   = 16'h01e8;
  localparam logic [15:0] GLYPH_NONE     = 16'h0000;

  typedef enum logic [2:0] {S_IDLE, S_TEXT, S_FUNC, S_COUNT, S_ARGS} msg_state_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_BANK_KEY;
  logic [23:0] cfg_wdata = '0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_data = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_data;

  scrambled_message_text_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the bank registers and the decoder state
  logic [15:0] bank_key_sh = '0;
  logic [15:0] count_sh = '0;
  logic [23:0] size_sh = '0;
  logic [15:0] keystream = '0;
  logic [16:0] words_left = '0;
  msg_state_t  msg_state = S_IDLE;
  logic [15:0] held_fn = '0;
  logic [15:0] args_left = '0;
  logic [15:0] first_arg = '0;
  logic        have_arg = 1'b0;

  out_item_t   item_tokens[$];
  out_item_t   decoded_queue[$];
  out_item_t   head_result;
  logic [15:0] msg_codes[$];

  bit steady = 1'b0;
  int busy_items = 0;
  int mismatches = 0;
  int pop_wait = 0;
  int quiet_cycles = 0;

  function automatic int draw_wait();
    if (steady) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [31:0] seed_of(input logic [15:0] idx);
    logic [31:0] p;
    p = 32'(bank_key_sh) * SEED_MUL * (32'(idx) + 32'd1);
    return {p[15:0], p[15:0]};
  endfunction

  function automatic string glyph_text(input logic [15:0] c);
    case (c)
      16'h01de, 16'h01e2: return " ";
      16'h01ab: return "!";
      16'h01ac: return "?";
      16'h01ad: return ",";
      16'h01ae, 16'h01b0: return ".";
      16'h01af: return "...";
      16'h01b1: return "/";
      16'h01b2, 16'h01b3: return "'";
      16'h01b4, 16'h01b5, 16'h01b6: return "\"";
      16'h01b9: return "(";
      16'h01ba: return ")";
      16'h01bb: return "M";
      16'h01bc: return "F";
      16'h01bd: return "+";
      16'h01be: return "-";
      16'h01bf: return "*";
      16'h01c0: return "#";
      16'h01c1: return "=";
      16'h01c2: return "&";
      16'h01c3: return "~";
      16'h01c4: return ":";
      16'h01c5: return ";";
      16'h01d0: return "@";
      16'h01d2: return "%";
      16'h01e8: return "deg";
      16'h01e9: return "_";
      16'h0188: return "e";
      16'h0167: return "E";
      16'h0170: return "N";
      16'h0190: return "n";
      default: return "";
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.operation     = 1'($urandom);
    it.message_index = 16'($urandom);
    it.raw_offset    = $urandom;
    it.raw_length    = $urandom;
    it.text_word     = 16'($urandom);
    return it;
  endfunction

  task automatic add_token(input kind_t k, input logic [6:0] ch, input logic [15:0] slot);
    out_item_t r;
    r = '0;
    r.kind = k;
    r.ascii_char = ch;
    r.string_slot = slot;
    item_tokens.insert(item_tokens.size(), r);
  endtask

  task automatic add_code(input logic [15:0] code);
    msg_codes.insert(msg_codes.size(), code);
  endtask

  task automatic add_control();
    if (held_fn == FN_PLAYER)
      add_token(KIND_PLAYER, 7'd0, 16'd0);
    else if (held_fn == FN_SLOT)
      add_token(KIND_SLOT, 7'd0, have_arg ? first_arg : 16'd0);
  endtask

  task automatic add_glyph(input logic [15:0] c);
    string s;
    byte   b;
    int    i;
    if (c >= 16'h0121 && c <= 16'h012a) begin
      add_token(KIND_CHAR, 7'(16'h30 + c - 16'h0121), 16'd0);
    end else if (c >= 16'h012b && c <= 16'h0144) begin
      add_token(KIND_CHAR, 7'(16'h41 + c - 16'h012b), 16'd0);
    end else if (c >= 16'h0145 && c <= 16'h015e) begin
      add_token(KIND_CHAR, 7'(16'h61 + c - 16'h0145), 16'd0);
    end else begin
      s = glyph_text(c);
      for (i = 0; i < s.len(); i++) begin
        b = s[i];
        add_token(KIND_CHAR, b[6:0], 16'd0);
      end
    end
  endtask

  // work out every result of one accepted transaction and queue them
  task automatic decode_item(input in_item_t it);
    logic [31:0] seed;
    logic [31:0] off;
    logic [31:0] len;
    logic [31:0] start;
    logic [15:0] c;
    logic [16:0] words_before;
    logic        ok;
    logic        closed;
    out_item_t   r;
    item_tokens.delete();
    if (it.operation == OP_HEADER) begin
      busy_items++;
      seed = seed_of(it.message_index);
      off = it.raw_offset ^ seed;
      len = it.raw_length ^ seed;
      ok = count_sh != 16'd0 && 32'd4 + 32'd8 * 32'(count_sh) <= 32'(size_sh) &&
           it.message_index < count_sh && len <= LEN_LIMIT &&
           64'(off) + 64'(len) * 64'd2 <= 64'(size_sh);
      msg_state = S_IDLE;
      words_left = '0;
      r = '0;
      r.kind = KIND_HDR;
      r.header_offset = off;
      r.header_ok = ok;
      if (ok) begin
        r.header_length = len[16:0];
        start = (32'(it.message_index) + 32'd1) * START_MUL;
        keystream = start[15:0];
        words_left = len[16:0];
        held_fn = '0;
        args_left = '0;
        first_arg = '0;
        have_arg = 1'b0;
        if (len != 32'd0) msg_state = S_TEXT;
      end
      item_tokens.insert(item_tokens.size(), r);
    end else if (msg_state != S_IDLE) begin
      busy_items++;
      c = it.text_word ^ keystream;
      words_before = words_left;
      keystream = keystream + KEY_ADVANCE;
      words_left = words_left - 17'd1;
      closed = 1'b0;
      case (msg_state)
        S_TEXT: begin
          if (c == CODE_END) begin
            add_token(KIND_END, 7'd0, 16'd0);
            msg_state = S_IDLE;
            words_left = '0;
            closed = 1'b1;
          end else if (c == CODE_CTRL && words_before >= 17'd3) begin
            msg_state = S_FUNC;
          end else if (c == CODE_NL || c == CODE_NL_ALT) begin
            add_token(KIND_NL, 7'd0, 16'd0);
          end else if (c == CODE_PAGE) begin
            add_token(KIND_PAGE, 7'd0, 16'd0);
          end else begin
            add_glyph(c);
          end
        end
        S_FUNC: begin
          held_fn = c;
          msg_state = S_COUNT;
        end
        S_COUNT: begin
          args_left = c;
          first_arg = '0;
          have_arg = 1'b0;
          if (c == 16'd0) begin
            add_control();
            msg_state = S_TEXT;
          end else begin
            msg_state = S_ARGS;
          end
        end
        default: begin
          if (!have_arg) begin
            first_arg = c;
            have_arg = 1'b1;
          end
          args_left = args_left - 16'd1;
          if (args_left == 16'd0) begin
            add_control();
            msg_state = S_TEXT;
          end
        end
      endcase
      // message exhausted: flush a cut-short control, then close
      if (!closed && words_left == 17'd0) begin
        if (msg_state == S_ARGS) add_control();
        add_token(KIND_END, 7'd0, 16'd0);
        msg_state = S_IDLE;
      end
    end
    if (item_tokens.size() != 0) begin
      r = item_tokens[item_tokens.size() - 1];
      r.last = 1'b1;
      item_tokens[item_tokens.size() - 1] = r;
    end
    while (item_tokens.size() != 0) begin
      r = item_tokens.pop_front();
      decoded_queue.insert(decoded_queue.size(), r);
    end
  endtask

  task automatic send_item(input in_item_t it);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    decode_item(it);
  endtask

  task automatic open_message(input logic [15:0] idx, input logic [31:0] off,
                              input logic [31:0] len);
    in_item_t it;
    logic [31:0] seed;
    seed = seed_of(idx);
    it = rand_item();
    it.operation = OP_HEADER;
    it.message_index = idx;
    it.raw_offset = off ^ seed;
    it.raw_length = len ^ seed;
    send_item(it);
  endtask

  // scramble with the keystream in force when the word goes in
  task automatic send_code(input logic [15:0] code);
    in_item_t it;
    it = rand_item();
    it.operation = OP_TEXT;
    it.text_word = code ^ keystream;
    send_item(it);
  endtask

  task automatic send_codes(input int count);
    int i;
    for (i = 0; i < count && i < msg_codes.size(); i++) send_code(msg_codes[i]);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_bank(input logic [15:0] key, input logic [15:0] count,
                            input logic [23:0] size);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_BANK_KEY;
    cfg_wdata <= {8'h00, key};
    @(posedge clk);
    bank_key_sh = key;
    cfg_idx <= CFG_MESSAGE_COUNT;
    cfg_wdata <= {8'h00, count};
    @(posedge clk);
    count_sh = count;
    cfg_idx <= CFG_BANK_SIZE;
    cfg_wdata <= size;
    @(posedge clk);
    size_sh = size;
    cfg_we <= 1'b0;
  endtask

  // fill msg_codes with a plausible message of len words
  task automatic build_message(input int len);
    int sel;
    int n;
    int i;
    logic [15:0] argc;
    msg_codes.delete();
    while (msg_codes.size() < len) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        add_code(16'($urandom_range(16'h0121, 16'h015e)));
      end else if (sel < 55) begin
        add_code(16'($urandom_range(16'h01ab, 16'h01e9)));
      end else if (sel < 58) begin
        case ($urandom_range(0, 3))
          0: add_code(16'h0188);
          1: add_code(16'h0167);
          2: add_code(16'h0170);
          default: add_code(16'h0190);
        endcase
      end else if (sel < 64) begin
        add_code($urandom_range(0, 1) ? CODE_NL : CODE_NL_ALT);
      end else if (sel < 68) begin
        add_code(CODE_PAGE);
      end else if (sel < 76) begin
        add_code(16'($urandom));
      end else if (sel < 96) begin
        add_code(CODE_CTRL);
        n = $urandom_range(0, 19);
        add_code(n < 10 ? FN_PLAYER : n < 17 ? FN_SLOT : 16'($urandom));
        argc = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        add_code(argc);
        n = (argc > 16'd6) ? 6 : int'(argc);
        for (i = 0; i < n; i++) add_code(16'($urandom));
      end else begin
        add_code(CODE_END);
      end
    end
    while (msg_codes.size() > len) msg_codes.delete(msg_codes.size() - 1);
  endtask

  task automatic test_reset_bank();
    in_item_t it;
    // bank registers are still zero: any header must fail
    it = rand_item();
    it.operation = OP_HEADER;
    send_item(it);
    send_code(16'($urandom));
    wait_idle();
  endtask

  task automatic test_header_checks();
    steady = 1'b1;
    write_bank(16'h1234, 16'd4, 24'd100);
    open_message(16'd4, 32'd0, 32'd1);
    open_message(16'd3, 32'd0, 32'd65537);
    open_message(16'd3, 32'd91, 32'd5);
    open_message(16'd2, 32'd90, 32'd5);
    open_message(16'd1, 32'd10, 32'd0);
    send_code(GLYPH_DIGIT0);
    wait_idle();
    steady = 1'b0;
    write_bank(16'h1234, 16'd4, 24'd35);
    open_message(16'd0, 32'd0, 32'd1);
    wait_idle();
    write_bank(16'hffff, 16'hffff, 24'hffffff);
    open_message(16'hfffe, 32'h00ffffff - 32'd131072, LEN_LIMIT);
    open_message(16'hffff, 32'd0, 32'd1);
    wait_idle();
  endtask

  task automatic test_text_codes();
    write_bank(16'h8001, 16'd16, 24'd4096);
    open_message(16'd0, 32'd0, 32'd20);
    msg_codes = '{GLYPH_DIGIT0, GLYPH_LOWER_Z, GLYPH_ELLIPSIS, GLYPH_DEGREE, CODE_NL,
                  CODE_NL_ALT, CODE_PAGE, GLYPH_NONE, CODE_CTRL, FN_PLAYER, 16'd0,
                  CODE_CTRL, FN_SLOT, 16'd2, 16'h0042, 16'h0007, CODE_END, GLYPH_UPPER_A};
    send_codes(msg_codes.size());
    wait_idle();
  endtask

  task automatic test_message_runout();
    steady = 1'b1;
    // control mark too close to the end falls through as an unmapped glyph
    open_message(16'd5, 32'd0, 32'd2);
    msg_codes = '{CODE_CTRL, GLYPH_UPPER_A};
    send_codes(2);
    // arguments cut short by the end of the message
    open_message(16'd6, 32'd0, 32'd4);
    msg_codes = '{CODE_CTRL, FN_SLOT, 16'd3, 16'h0007};
    send_codes(4);
    steady = 1'b0;
    open_message(16'd7, 32'd0, 32'd1);
    send_code(GLYPH_ELLIPSIS);
    // restart part way through a message
    open_message(16'd8, 32'd0, 32'd6);
    send_code(GLYPH_UPPER_A);
    send_code(CODE_CTRL);
    open_message(16'd9, 32'd0, 32'd0);
    wait_idle();
  endtask

  task automatic run_random_phase(input int quota);
    int target;
    int len;
    int sel;
    int room;
    in_item_t it;
    target = busy_items + quota;
    while (busy_items < target) begin
      steady = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        it = rand_item();
        it.operation = OP_HEADER;
        send_item(it);
      end else if (sel == 1) begin
        it = rand_item();
        it.operation = OP_TEXT;
        send_item(it);
      end else begin
        sel = $urandom_range(0, 19);
        len = (sel == 0) ? 0 : (sel < 4) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        room = int'(size_sh) - 2 * len;
        open_message(16'($urandom_range(0, int'(count_sh) - 1)),
                     32'($urandom_range(0, room)), 32'(len));
        build_message(len);
        send_codes(($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len);
      end
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    write_bank(16'($urandom), 16'($urandom_range(1, 40)), 24'($urandom_range(2000, 50000)));
    run_random_phase(64);
    write_bank(16'hffff, 16'hffff, 24'hffffff);
    run_random_phase(64);
    write_bank(16'h0000, 16'd1, 24'd108);
    run_random_phase(64);
    write_bank(16'($urandom), 16'($urandom_range(1, 65535)), 24'hffffff);
    run_random_phase(64);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall before each pop, compare against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (decoded_queue.size() == 0) begin
        $error("unexpected transaction: kind %0d", out_data.kind);
        mismatches++;
      end else begin
        head_result = decoded_queue.pop_front();
        check_field("kind", 32'(head_result.kind), 32'(out_data.kind));
        check_field("header_offset", head_result.header_offset, out_data.header_offset);
        check_field("header_length", 32'(head_result.header_length),
                    32'(out_data.header_length));
        check_field("header_ok", 32'(head_result.header_ok), 32'(out_data.header_ok));
        check_field("ascii_char", 32'(head_result.ascii_char), 32'(out_data.ascii_char));
        check_field("string_slot", 32'(head_result.string_slot), 32'(out_data.string_slot));
        check_field("last", 32'(head_result.last), 32'(out_data.last));
      end
      pop_wait = draw_wait();
    end
    if (pop_wait > 0) begin
      out_pop <= 1'b0;
      pop_wait--;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("** scrambled_message_text_decoder: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_bank();
    test_header_checks();
    test_text_codes();
    test_message_runout();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("** scrambled_message_text_decoder: PASSED **");
    end else begin
      $display("** scrambled_message_text_decoder: FAILED **");
    end
    $finish;
  end

endmodule
